### hdl/open_loop_motor_startup_ramp_unit_macros.svh
// Assertion macros shared by the startup ramp unit.
`ifndef OPEN_LOOP_MOTOR_STARTUP_RAMP_UNIT_MACROS_SVH
`define OPEN_LOOP_MOTOR_STARTUP_RAMP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define OLSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define OLSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/olsr_pkg.sv
package olsr_pkg;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// Sequencer modes.
	localparam logic [1:0] MODE_STOPPED  = 2'd0;
	localparam logic [1:0] MODE_ALIGNING = 2'd1;
	localparam logic [1:0] MODE_RUNNING  = 2'd2;
	localparam logic [1:0] MODE_FAULT    = 2'd3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_VOLTAGE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RUN_VOLTAGE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_TICKS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_FREQUENCY  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQUENCY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_RATE_HZ      = 3'd6;

	// Register values after reset.
	localparam logic [14:0] RST_ALIGN_VOLTAGE    = 15'd983;
	localparam logic [14:0] RST_RUN_VOLTAGE      = 15'd1311;
	localparam logic [15:0] RST_ALIGN_TICKS      = 16'd5000;
	localparam logic [19:0] RST_START_FREQUENCY  = 20'd2000;
	localparam logic [19:0] RST_TARGET_FREQUENCY = 20'd10000;
	localparam logic [15:0] RST_RAMP_TICKS       = 16'd30000;
	localparam logic [16:0] RST_PWM_RATE_HZ      = 17'd20000;

	// Hertz to millihertz scale of the phase step divisor.
	localparam logic [9:0] MHZ_SCALE = 10'd1000;

	// Shared serial divider: 52-bit dividend, 27-bit divisor.
	localparam int DVD_W      = 52;
	localparam int DVSR_W     = 27;
	localparam int DIV1_STEPS = 36;
	localparam int DIV2_STEPS = 52;
	localparam int CNT_W      = 6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic eval;
		logic ramp_mul;
		logic ramp_hold;
		logic div1_load;
		logic div2_load;
		logic div_step;
		logic freq_upd;
		logic phase_upd;
		logic out_load;
	} olsr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go;
		logic ramp_active;
		logic out_busy;
	} olsr_stat_t;

endpackage

### hdl/open_loop_motor_startup_ramp_unit.sv
// Start, stop, refused and fault items and alignment ticks but the last go straight from
// evaluation to the output load; a tick inside the ramp runs the 36-step interpolation
// divide and then the 52-step phase step divide, and a later tick runs only the latter.
// One item at a time: the input reopens once the result is loaded, which waits while an
// earlier result is held. Reset: arst_n clears mode to stopped, all counters, phase and
// frequency, and loads the register defaults; no clearing pass follows.
`include "open_loop_motor_startup_ramp_unit_macros.svh"

module open_loop_motor_startup_ramp_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [olsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [olsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          op,
	input  logic                                output_on,
	input  logic                                sample_ok,
	input  logic                                overcurrent,
	input  logic                                enable_ok,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          mode,
	output logic [15:0]                         angle,
	output logic [19:0]                         frequency,
	output logic signed [15:0]                  volt_d,
	output logic signed [15:0]                  volt_q,
	output logic                                apply,
	output logic                                accepted,
	output logic                                enable_req,
	output logic                                disable_req,
	output logic                                estop_req
);

	olsr_pkg::olsr_cmd_t  cmd;
	olsr_pkg::olsr_stat_t stat;

	// Sequencing controller.
	olsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// State, ramp arithmetic, divider and output register.
	olsr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.output_on   (output_on),
		.sample_ok   (sample_ok),
		.overcurrent (overcurrent),
		.enable_ok   (enable_ok),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.mode        (mode),
		.angle       (angle),
		.frequency   (frequency),
		.volt_d      (volt_d),
		.volt_q      (volt_q),
		.apply       (apply),
		.accepted    (accepted),
		.enable_req  (enable_req),
		.disable_req (disable_req),
		.estop_req   (estop_req)
	);

	// Only one item is in flight: a transfer in closes the input until the result is loaded.
	`OLSR_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second item taken while busy")
	// A result never drives both axes, and no voltage without apply.
	`OLSR_ASSERT_NOW(a_one_axis, out_valid, (volt_d == 16'sd0) || (volt_q == 16'sd0), "both axes driven")
	`OLSR_ASSERT_NOW(a_no_apply_zero, out_valid && !apply, (volt_d == 16'sd0) && (volt_q == 16'sd0), "voltage without apply")
	// An accepted start leaves the unit aligning with an enable request.
	`OLSR_ASSERT_NOW(a_start_ok, out_valid && accepted, (mode == olsr_pkg::MODE_ALIGNING) && enable_req, "accepted start not aligning")
	// An emergency stop only comes with the fault mode.
	`OLSR_ASSERT_NOW(a_estop_fault, out_valid && estop_req, mode == olsr_pkg::MODE_FAULT, "estop outside fault")

endmodule

### hdl/olsr_ctrl.sv
module olsr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  olsr_pkg::olsr_stat_t   stat,
	output olsr_pkg::olsr_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EVAL  = 4'd1;
	localparam logic [3:0] ST_CHK   = 4'd2;
	localparam logic [3:0] ST_LOAD1 = 4'd3;
	localparam logic [3:0] ST_DIV1  = 4'd4;
	localparam logic [3:0] ST_FREQ  = 4'd5;
	localparam logic [3:0] ST_LOAD2 = 4'd6;
	localparam logic [3:0] ST_DIV2  = 4'd7;
	localparam logic [3:0] ST_PHASE = 4'd8;
	localparam logic [3:0] ST_FIN   = 4'd9;

	localparam logic [olsr_pkg::CNT_W-1:0] DIV1_LAST =
		olsr_pkg::CNT_W'(olsr_pkg::DIV1_STEPS - 1);
	localparam logic [olsr_pkg::CNT_W-1:0] DIV2_LAST =
		olsr_pkg::CNT_W'(olsr_pkg::DIV2_STEPS - 1);

	logic [3:0]                   state_q;
	logic [3:0]                   state_d;
	logic [olsr_pkg::CNT_W-1:0]   cnt_q;
	logic [olsr_pkg::CNT_W-1:0]   cnt_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.go ? ST_CHK : ST_FIN;
			end
			ST_CHK: begin
				if (stat.ramp_active) begin
					cmd.ramp_mul = 1'b1;
					state_d      = ST_LOAD1;
				end else begin
					cmd.ramp_hold = 1'b1;
					state_d       = ST_LOAD2;
				end
			end
			ST_LOAD1: begin
				cmd.div1_load = 1'b1;
				cnt_d         = DIV1_LAST;
				state_d       = ST_DIV1;
			end
			ST_DIV1: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_FREQ;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_FREQ: begin
				cmd.freq_upd = 1'b1;
				state_d      = ST_LOAD2;
			end
			ST_LOAD2: begin
				cmd.div2_load = 1'b1;
				cnt_d         = DIV2_LAST;
				state_d       = ST_DIV2;
			end
			ST_DIV2: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_PHASE;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			ST_PHASE: begin
				cmd.phase_upd = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				// Hand the result over once the output register is free.
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### hdl/olsr_dpath.sv
module olsr_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  olsr_pkg::olsr_cmd_t                 cmd,
	output olsr_pkg::olsr_stat_t                stat,
	input  logic                                cfg_we,
	input  logic [olsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [olsr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          op,
	input  logic                                output_on,
	input  logic                                sample_ok,
	input  logic                                overcurrent,
	input  logic                                enable_ok,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [1:0]                          mode,
	output logic [15:0]                         angle,
	output logic [19:0]                         frequency,
	output logic signed [15:0]                  volt_d,
	output logic signed [15:0]                  volt_q,
	output logic                                apply,
	output logic                                accepted,
	output logic                                enable_req,
	output logic                                disable_req,
	output logic                                estop_req
);

	// Configuration registers.
	logic [14:0] align_voltage_q;
	logic [14:0] run_voltage_q;
	logic [15:0] align_ticks_q;
	logic [19:0] start_freq_q;
	logic [19:0] target_freq_q;
	logic [15:0] ramp_ticks_q;
	logic [16:0] pwm_rate_q;

	// Captured input item.
	logic [1:0]  op_q;
	logic        on_q;
	logic        sok_q;
	logic        oc_q;
	logic        eok_q;

	// Sequencer state and per-item flags.
	logic [1:0]  mode_q;
	logic [15:0] tick_q;
	logic [31:0] phase_q;
	logic [19:0] freq_q;
	logic [15:0] angle_q;
	logic [14:0] vd_q;
	logic [14:0] vq_q;
	logic        apply_q;
	logic        accepted_q;
	logic        en_q;
	logic        dis_q;
	logic        estop_q;

	// Ramp and divider datapath.
	logic [19:0]                        abs_diff;
	logic [35:0]                        prod_q;
	logic                               neg_q;
	logic [19:0]                        fcalc_q;
	logic [20:0]                        part;
	logic [20:0]                        fsum;
	logic [olsr_pkg::DVD_W-1:0]         dq_q;
	logic [olsr_pkg::DVSR_W-1:0]        rem_q;
	logic [olsr_pkg::DVSR_W-1:0]        dvsr_q;
	logic [olsr_pkg::DVSR_W:0]          trial;
	logic [olsr_pkg::DVSR_W+1:0]        sub;
	logic                               ge;
	logic [31:0]                        step;
	logic [31:0]                        phase_nxt;
	logic [15:0]                        tick_inc;
	logic                               align_done;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  res_mode_q;
	logic [15:0] res_angle_q;
	logic [19:0] res_freq_q;
	logic [14:0] res_vd_q;
	logic [14:0] res_vq_q;
	logic        res_apply_q;
	logic        res_acc_q;
	logic        res_en_q;
	logic        res_dis_q;
	logic        res_estop_q;

	// Configuration writes; indexes outside the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_voltage_q <= olsr_pkg::RST_ALIGN_VOLTAGE;
			run_voltage_q   <= olsr_pkg::RST_RUN_VOLTAGE;
			align_ticks_q   <= olsr_pkg::RST_ALIGN_TICKS;
			start_freq_q    <= olsr_pkg::RST_START_FREQUENCY;
			target_freq_q   <= olsr_pkg::RST_TARGET_FREQUENCY;
			ramp_ticks_q    <= olsr_pkg::RST_RAMP_TICKS;
			pwm_rate_q      <= olsr_pkg::RST_PWM_RATE_HZ;
		end else if (cfg_we) begin
			unique case (cfg_index)
				olsr_pkg::CFG_ALIGN_VOLTAGE:    align_voltage_q <= cfg_data[14:0];
				olsr_pkg::CFG_RUN_VOLTAGE:      run_voltage_q   <= cfg_data[14:0];
				olsr_pkg::CFG_ALIGN_TICKS:      align_ticks_q   <= cfg_data[15:0];
				olsr_pkg::CFG_START_FREQUENCY:  start_freq_q    <= cfg_data[19:0];
				olsr_pkg::CFG_TARGET_FREQUENCY: target_freq_q   <= cfg_data[19:0];
				olsr_pkg::CFG_RAMP_TICKS:       ramp_ticks_q    <= cfg_data[15:0];
				olsr_pkg::CFG_PWM_RATE_HZ:      pwm_rate_q      <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// Input item capture at the transfer.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			on_q  <= output_on;
			sok_q <= sample_ok;
			oc_q  <= overcurrent;
			eok_q <= enable_ok;
		end
	end

	// Decision and status toward the controller.
	assign tick_inc   = tick_q + 16'd1;
	assign align_done = (tick_inc >= align_ticks_q);

	assign stat.go = (op_q == olsr_pkg::OP_TICK) && on_q &&
		((mode_q == olsr_pkg::MODE_RUNNING) ||
		 ((mode_q == olsr_pkg::MODE_ALIGNING) && align_done));
	assign stat.ramp_active = (tick_q < ramp_ticks_q);
	assign stat.out_busy    = out_valid_q && !out_ready;

	// Interpolated frequency: the magnitude quotient takes the sign of the slope,
	// which truncates toward zero.
	assign abs_diff = (target_freq_q < start_freq_q) ? (start_freq_q - target_freq_q)
		: (target_freq_q - start_freq_q);
	assign part = neg_q ? (21'd0 - {1'b0, dq_q[19:0]}) : {1'b0, dq_q[19:0]};
	assign fsum = {1'b0, start_freq_q} + part;

	// One restoring division step per cycle.
	assign trial = {rem_q, dq_q[olsr_pkg::DVD_W-1]};
	assign sub   = {1'b0, trial} - {2'b00, dvsr_q};
	assign ge    = !sub[olsr_pkg::DVSR_W+1];

	// A zero tick rate gives no phase advance.
	assign step      = (pwm_rate_q == '0) ? 32'd0 : dq_q[31:0];
	assign phase_nxt = phase_q + step;

	always_ff @(posedge clk) begin
		if (cmd.ramp_mul) begin
			prod_q <= {16'd0, abs_diff} * {20'd0, tick_q};
			neg_q  <= (target_freq_q < start_freq_q);
		end
		if (cmd.ramp_hold) begin
			fcalc_q <= target_freq_q;
		end else if (cmd.freq_upd) begin
			fcalc_q <= fsum[19:0];
		end
		if (cmd.div1_load) begin
			dq_q   <= {prod_q, 16'd0};
			rem_q  <= '0;
			dvsr_q <= {11'd0, ramp_ticks_q};
		end else if (cmd.div2_load) begin
			dq_q   <= {fcalc_q, 32'd0};
			rem_q  <= '0;
			dvsr_q <= {10'd0, pwm_rate_q} * {17'd0, olsr_pkg::MHZ_SCALE};
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[olsr_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? sub[olsr_pkg::DVSR_W-1:0] : trial[olsr_pkg::DVSR_W-1:0];
		end
	end

	// Sequencer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= olsr_pkg::MODE_STOPPED;
			tick_q     <= '0;
			phase_q    <= '0;
			freq_q     <= '0;
			angle_q    <= '0;
			vd_q       <= '0;
			vq_q       <= '0;
			apply_q    <= 1'b0;
			accepted_q <= 1'b0;
			en_q       <= 1'b0;
			dis_q      <= 1'b0;
			estop_q    <= 1'b0;
		end else if (cmd.eval) begin
			vd_q       <= '0;
			vq_q       <= '0;
			apply_q    <= 1'b0;
			accepted_q <= 1'b0;
			en_q       <= 1'b0;
			dis_q      <= 1'b0;
			estop_q    <= 1'b0;
			unique case (op_q)
				olsr_pkg::OP_START: begin
					if (sok_q && !oc_q && !on_q) begin
						phase_q <= '0;
						tick_q  <= '0;
						freq_q  <= '0;
						angle_q <= '0;
						vd_q    <= align_voltage_q;
						apply_q <= 1'b1;
						en_q    <= 1'b1;
						if (eok_q) begin
							mode_q     <= olsr_pkg::MODE_ALIGNING;
							accepted_q <= 1'b1;
						end else begin
							mode_q  <= olsr_pkg::MODE_FAULT;
							estop_q <= 1'b1;
						end
					end
				end
				olsr_pkg::OP_STOP: begin
					dis_q  <= 1'b1;
					mode_q <= olsr_pkg::MODE_STOPPED;
					freq_q <= '0;
				end
				olsr_pkg::OP_TICK: begin
					if ((mode_q == olsr_pkg::MODE_ALIGNING) ||
						(mode_q == olsr_pkg::MODE_RUNNING)) begin
						if (!on_q) begin
							mode_q <= olsr_pkg::MODE_FAULT;
						end else if (mode_q == olsr_pkg::MODE_ALIGNING) begin
							if (align_done) begin
								tick_q <= '0;
								mode_q <= olsr_pkg::MODE_RUNNING;
							end else begin
								tick_q <= tick_inc;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.freq_upd) begin
			tick_q <= tick_inc;
		end else if (cmd.phase_upd) begin
			phase_q <= phase_nxt;
			angle_q <= phase_nxt[31:16];
			freq_q  <= fcalc_q;
			vq_q    <= run_voltage_q;
			apply_q <= 1'b1;
		end
	end

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_mode_q  <= mode_q;
			res_angle_q <= angle_q;
			res_freq_q  <= freq_q;
			res_vd_q    <= vd_q;
			res_vq_q    <= vq_q;
			res_apply_q <= apply_q;
			res_acc_q   <= accepted_q;
			res_en_q    <= en_q;
			res_dis_q   <= dis_q;
			res_estop_q <= estop_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign mode        = res_mode_q;
	assign angle       = res_angle_q;
	assign frequency   = res_freq_q;
	assign volt_d      = signed'({1'b0, res_vd_q});
	assign volt_q      = signed'({1'b0, res_vq_q});
	assign apply       = res_apply_q;
	assign accepted    = res_acc_q;
	assign enable_req  = res_en_q;
	assign disable_req = res_dis_q;
	assign estop_req   = res_estop_q;

endmodule
